FILE: hdl/nlwm_pkg.sv
package nlwm_pkg;

    typedef enum logic [1:0] {
        MODE_OBSERVE  = 2'd0,
        MODE_TICK     = 2'd1,
        MODE_REGISTER = 2'd2,
        MODE_UNUSED   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_OBSERVE  = 2'd0,
        KIND_REGISTER = 2'd1,
        KIND_LOSS     = 2'd2,
        KIND_RSVD     = 2'd3
    } kind_t;

    typedef enum logic {
        REG_DEADTIME = 1'b0,
        REG_LOSS_EN  = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_EMIT  = 2'd2
    } state_t;

    localparam logic [15:0] DEADTIME_RESET = 16'd1000;
    localparam int          MAX_RESULTS    = 16;
    localparam logic [31:0] SAT_MAX        = 32'hFFFF_FFFF;

    // word travelling down the chain of cells
    typedef struct packed {
        logic        vld;
        logic [1:0]  mode;
        logic [7:0]  node_id;
        logic [15:0] packet_id;
        logic [15:0] timeout_ticks;
        logic        hit;
        logic        allocated;
        logic        skip;
        logic [31:0] skips;
        logic [4:0]  emitted;
        logic [15:0] deadtime;
        logic        loss_en;
    } chain_t;

    // result word leaving a cell
    typedef struct packed {
        logic        vld;
        logic [7:0]  node_id;
        logic [31:0] skips;
    } loss_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == SAT_MAX) ? v : v + 32'd1;
    endfunction

endpackage

FILE: hdl/nlwm_if.sv
interface nlwm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  node_id;
    logic [15:0] packet_id;
    logic [15:0] timeout_ticks;
    modport source (output valid, mode, node_id, packet_id, timeout_ticks, input ready);
    modport sink (input valid, mode, node_id, packet_id, timeout_ticks, output ready);
endinterface

interface nlwm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  node_out;
    logic        matched;
    logic        skipped;
    logic [31:0] node_skips;
    logic [31:0] total_skips;
    logic        last;
    modport source (output valid, kind, node_out, matched, skipped, node_skips,
                    total_skips, last, input ready);
    modport sink (input valid, kind, node_out, matched, skipped, node_skips,
                  total_skips, last, output ready);
endinterface

interface nlwm_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/nlwm_cell.sv
module nlwm_cell
    import nlwm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  chain_t chain_in,
    output chain_t chain_out,
    output loss_t  loss_out
);

    logic        valid_reg,    valid_next;
    logic        dead_reg,     dead_next;
    logic [7:0]  node_reg,     node_next;
    logic [15:0] timeout_reg,  timeout_next;
    logic [15:0] last_id_reg,  last_id_next;
    logic [31:0] skips_reg,    skips_next;
    logic [15:0] count_reg,    count_next;
    chain_t      chain_reg,    chain_next;
    loss_t       loss_reg,     loss_next;

    logic        match;
    logic        skip;

    assign match = chain_in.vld && valid_reg && !chain_in.hit
                   && (node_reg == chain_in.node_id);
    assign skip  = chain_in.packet_id != (last_id_reg + 16'd1);

    always_comb
    begin
        valid_next   = valid_reg;
        dead_next    = dead_reg;
        node_next    = node_reg;
        timeout_next = timeout_reg;
        last_id_next = last_id_reg;
        skips_next   = skips_reg;
        count_next   = count_reg;
        chain_next   = chain_in;
        loss_next    = '0;
        if (chain_in.vld)
        begin
            unique case (mode_t'(chain_in.mode))
                MODE_OBSERVE:
                begin
                    if (match)
                    begin
                        last_id_next   = chain_in.packet_id;
                        if (skip)
                        begin
                            skips_next = sat_inc(skips_reg);
                        end
                        if (!dead_reg)
                        begin
                            count_next = timeout_reg;
                        end
                        chain_next.hit   = 1'b1;
                        chain_next.skip  = skip;
                        chain_next.skips = skip ? sat_inc(skips_reg) : skips_reg;
                    end
                end
                MODE_REGISTER:
                begin
                    if (!valid_reg && !chain_in.allocated)
                    begin
                        valid_next   = 1'b1;
                        dead_next    = 1'b0;
                        node_next    = chain_in.node_id;
                        timeout_next = chain_in.timeout_ticks;
                        last_id_next = '0;
                        skips_next   = '0;
                        count_next   = chain_in.timeout_ticks;
                        chain_next.allocated = 1'b1;
                    end
                end
                MODE_TICK:
                begin
                    if (valid_reg)
                    begin
                        if (count_reg > 16'd1)
                        begin
                            count_next = count_reg - 16'd1;
                        end
                        else if (dead_reg)
                        begin
                            dead_next  = 1'b0;
                            count_next = timeout_reg;
                        end
                        else if (chain_in.loss_en
                                 && chain_in.emitted < 5'(MAX_RESULTS))
                        begin
                            loss_next.vld     = 1'b1;
                            loss_next.node_id = node_reg;
                            loss_next.skips   = skips_reg;
                            chain_next.emitted = chain_in.emitted + 5'd1;
                            if (chain_in.deadtime != '0)
                            begin
                                dead_next  = 1'b1;
                                count_next = chain_in.deadtime;
                            end
                            else
                            begin
                                count_next = timeout_reg;
                            end
                        end
                        else
                        begin
                            count_next = timeout_reg;
                        end
                    end
                end
                MODE_UNUSED:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dead_reg  <= 1'b0;
            chain_reg <= '0;
            loss_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            dead_reg  <= dead_next;
            chain_reg <= chain_next;
            loss_reg  <= loss_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg    <= node_next;
        timeout_reg <= timeout_next;
        last_id_reg <= last_id_next;
        skips_reg   <= skips_next;
        count_reg   <= count_next;
    end

    assign chain_out = chain_reg;
    assign loss_out  = loss_reg;

endmodule

FILE: hdl/node_link_watchdog_monitor_top.sv
// Node link watchdog monitor. A row of MAX_NODES cells holds the table; each
// input word enters the head of the row and moves one cell per clock, and the
// result of an observe or register is registered onto the output once the
// word leaves the last cell. Loss events of a tick leave through a result
// queue of MAX_NODES words and are delivered in table order, once the tick
// word has left the last cell. The next input word is taken once all results
// of the previous one are gone. Observe and register give one result each, a
// tick one per expiring entry while loss reporting is enabled (at most
// sixteen).
module node_link_watchdog_monitor_top
    import nlwm_pkg::*;
#(
    parameter int MAX_NODES = 16
)
(
    input  logic clk,
    input  logic rst_n,
    nlwm_in_if.sink    in_ch,
    nlwm_out_if.source out_ch,
    nlwm_cfg_if.sink   cfg
);

    localparam int QW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);

    state_t      state_reg, state_next;
    logic [15:0] deadtime_reg;
    logic        loss_en_reg;
    logic [31:0] total_reg, total_next;

    chain_t chain [MAX_NODES+1];
    loss_t  loss  [MAX_NODES];

    loss_t   q_reg [MAX_NODES];
    logic [CW-1:0] q_cnt_reg, q_cnt_next;
    logic [CW-1:0] q_rd_reg,  q_rd_next;

    logic        o_valid_reg, o_valid_next;
    logic [1:0]  o_kind_reg,  o_kind_next;
    logic [7:0]  o_node_reg,  o_node_next;
    logic        o_match_reg, o_match_next;
    logic        o_skip_reg,  o_skip_next;
    logic [31:0] o_skips_reg, o_skips_next;
    logic        o_last_reg,  o_last_next;

    chain_t tail;
    logic   accept;

    assign in_ch.ready = (state_reg == ST_IDLE) && !o_valid_reg;
    assign accept      = in_ch.valid && in_ch.ready;
    assign cfg.ready   = 1'b1;

    always_comb
    begin
        chain[0]               = '0;
        chain[0].vld           = accept;
        chain[0].mode          = in_ch.mode;
        chain[0].node_id       = in_ch.node_id;
        chain[0].packet_id     = in_ch.packet_id;
        chain[0].timeout_ticks = in_ch.timeout_ticks;
        chain[0].deadtime      = deadtime_reg;
        chain[0].loss_en       = loss_en_reg;
    end

    for (genvar g = 0; g < MAX_NODES; g++)
    begin : g_cell
        nlwm_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1]),
            .loss_out  (loss[g])
        );
    end

    assign tail = chain[MAX_NODES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadtime_reg <= DEADTIME_RESET;
            loss_en_reg  <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (reg_index_t'(cfg.index))
                REG_DEADTIME: deadtime_reg <= cfg.data;
                REG_LOSS_EN:  loss_en_reg  <= cfg.data[0];
            endcase
        end
    end

    // collect loss words as they fall out of each cell, in table order
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_NODES; i++)
        begin
            if (loss[i].vld)
            begin
                q_reg[q_cnt_reg[QW-1:0]] <= loss[i];
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        total_next   = total_reg;
        q_cnt_next   = q_cnt_reg;
        q_rd_next    = q_rd_reg;
        o_valid_next = o_valid_reg;
        o_kind_next  = o_kind_reg;
        o_node_next  = o_node_reg;
        o_match_next = o_match_reg;
        o_skip_next  = o_skip_reg;
        o_skips_next = o_skips_reg;
        o_last_next  = o_last_reg;
        if (o_valid_reg && out_ch.ready)
        begin
            o_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                    q_cnt_next = '0;
                    q_rd_next  = '0;
                end
            end
            ST_SCAN:
            begin
                for (int i = 0; i < MAX_NODES; i++)
                begin
                    if (loss[i].vld)
                    begin
                        q_cnt_next = q_cnt_reg + CW'(1);
                    end
                end
                if (tail.vld)
                begin
                    unique case (mode_t'(tail.mode))
                        MODE_OBSERVE:
                        begin
                            if (tail.hit && tail.skip)
                            begin
                                total_next = sat_inc(total_reg);
                            end
                            o_valid_next = 1'b1;
                            o_kind_next  = KIND_OBSERVE;
                            o_node_next  = tail.node_id;
                            o_match_next = tail.hit;
                            o_skip_next  = tail.hit && tail.skip;
                            o_skips_next = tail.hit ? tail.skips : '0;
                            o_last_next  = 1'b1;
                            state_next   = ST_IDLE;
                        end
                        MODE_REGISTER:
                        begin
                            o_valid_next = 1'b1;
                            o_kind_next  = KIND_REGISTER;
                            o_node_next  = tail.node_id;
                            o_match_next = tail.allocated;
                            o_skip_next  = 1'b0;
                            o_skips_next = '0;
                            o_last_next  = 1'b1;
                            state_next   = ST_IDLE;
                        end
                        MODE_TICK:     state_next = ST_EMIT;
                        MODE_UNUSED:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (q_rd_reg == q_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!o_valid_reg || out_ch.ready)
                begin
                    o_valid_next = 1'b1;
                    o_kind_next  = KIND_LOSS;
                    o_node_next  = q_reg[q_rd_reg[QW-1:0]].node_id;
                    o_match_next = 1'b0;
                    o_skip_next  = 1'b0;
                    o_skips_next = q_reg[q_rd_reg[QW-1:0]].skips;
                    o_last_next  = (q_rd_reg + CW'(1)) == q_cnt_reg;
                    q_rd_next    = q_rd_reg + CW'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            q_cnt_reg   <= '0;
            q_rd_reg    <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            q_cnt_reg   <= q_cnt_next;
            q_rd_reg    <= q_rd_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_kind_reg  <= o_kind_next;
        o_node_reg  <= o_node_next;
        o_match_reg <= o_match_next;
        o_skip_reg  <= o_skip_next;
        o_skips_reg <= o_skips_next;
        o_last_reg  <= o_last_next;
    end

    assign out_ch.valid       = o_valid_reg;
    assign out_ch.kind        = o_kind_reg;
    assign out_ch.node_out    = o_node_reg;
    assign out_ch.matched     = o_match_reg;
    assign out_ch.skipped     = o_skip_reg;
    assign out_ch.node_skips  = o_skips_reg;
    assign out_ch.total_skips = total_reg;
    assign out_ch.last        = o_last_reg;

endmodule
